/* hw/rtl/tween_animation_pool_macros.svh */
// ----------------------------------------------------------------------------
// Tween animation pool assertion macros
// Shared property forms used by the checks of the tween pool.
// ----------------------------------------------------------------------------
`ifndef TWEEN_ANIMATION_POOL_MACROS_SVH
`define TWEEN_ANIMATION_POOL_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define TAP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tween pool check failed");

// Next-cycle implication, disabled while reset is applied.
`define TAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tween pool check failed");

`endif

/* hw/rtl/tap_pkg.sv */
// ----------------------------------------------------------------------------
// Tween animation pool package
// Shared codes, payload types and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package tap_pkg;

    localparam int POOL_SLOTS_DEF     = 16;
    localparam int PROPERTY_COUNT_DEF = 64;

    localparam int VAL_W = 32;

    localparam logic [2:0] ACT_START  = 3'd0;
    localparam logic [2:0] ACT_CANCEL = 3'd1;
    localparam logic [2:0] ACT_TICK   = 3'd2;
    localparam logic [2:0] ACT_SET    = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    localparam logic [2:0] KIND_START     = 3'd0;
    localparam logic [2:0] KIND_CANCEL    = 3'd1;
    localparam logic [2:0] KIND_TICK      = 3'd2;
    localparam logic [2:0] KIND_IDLE_TICK = 3'd3;
    localparam logic [2:0] KIND_READ      = 3'd4;

    typedef struct packed {
        logic [2:0]        action;
        logic [5:0]        prop_id;
        logic signed [31:0] value;
        logic [31:0]       span_ms;
        logic [31:0]       now_ms;
    } tap_req_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [3:0]        slot;
        logic [5:0]        prop_out;
        logic signed [31:0] value_out;
        logic              ok;
        logic              done_res;
        logic              any_active;
        logic              last;
    } tap_rsp_t;

    // One slot memory word.
    typedef struct packed {
        logic [31:0] base_val;
        logic [31:0] to_val;
        logic [31:0] duration;
        logic [31:0] start_time;
    } tap_slot_t;

endpackage

`default_nettype wire

/* hw/rtl/tap_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tap_muldiv.sv */
// ----------------------------------------------------------------------------
// Tween pool multiply-divide unit
// Computes (mag * elapsed) / divisor: a multiply step, then a restoring
// divide that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_muldiv
    import tap_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [VAL_W-1:0] mag,
    input  wire logic [VAL_W-1:0] elapsed,
    input  wire logic [VAL_W-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [VAL_W-1:0]      quotient
);

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} md_state_t;

    localparam int CNT_W = $clog2(VAL_W);

    md_state_t          state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [VAL_W-1:0]   a_reg;
    logic [VAL_W-1:0]   b_reg;
    logic [VAL_W-1:0]   d_reg;
    logic [VAL_W-1:0]   rem_reg;
    logic [VAL_W-1:0]   low_reg;
    logic [VAL_W-1:0]   q_reg;
    logic [2*VAL_W-1:0] prod;
    logic [VAL_W:0]     trial;
    logic               fits;

    assign prod  = a_reg * b_reg;
    assign trial = {rem_reg, low_reg[VAL_W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    // The remainder stays below the divisor because elapsed is below it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= mag;
                        b_reg     <= elapsed;
                        d_reg     <= divisor;
                        state_reg <= M_MUL;
                    end
                end
                M_MUL:
                begin
                    rem_reg   <= prod[2*VAL_W-1:VAL_W];
                    low_reg   <= prod[VAL_W-1:0];
                    cnt_reg   <= '0;
                    state_reg <= M_DIV;
                end
                M_DIV:
                begin
                    if (fits)
                    begin
                        rem_reg <= VAL_W'(trial - {1'b0, d_reg});
                    end
                    else
                    begin
                        rem_reg <= trial[VAL_W-1:0];
                    end
                    low_reg <= {low_reg[VAL_W-2:0], 1'b0};
                    q_reg   <= {q_reg[VAL_W-2:0], fits};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(VAL_W - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign busy     = state_reg != M_IDLE;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

/* hw/rtl/tween_animation_pool.sv */
// ----------------------------------------------------------------------------
// Tween animation pool: start, cancel, read and tick requests give registered responses,
// which wait on rsp_stall; a set only writes the store. Start and read first read the store;
// a tick visits each active slot in turn and divides unless the slot completes.
// Reset clears the slot flags; the store is then zeroed entry by entry while requests stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tween_animation_pool_macros.svh"

module tween_animation_pool
    import tap_pkg::*;
#(
    parameter int POOL_SLOTS     = POOL_SLOTS_DEF,
    parameter int PROPERTY_COUNT = PROPERTY_COUNT_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire tap_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output tap_rsp_t      rsp
);

    localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int AW = (PROPERTY_COUNT > 1) ? $clog2(PROPERTY_COUNT) : 1;
    localparam int SLOT_W = $bits(tap_slot_t);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_START, S_READ, S_CANCEL,
        T_FIRST, T_SCAN, T_LOAD, T_GO, T_WAIT, T_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [SW-1:0]     idx_reg, idx_next;
    logic [POOL_SLOTS-1:0] active_reg, active_next;
    logic [POOL_SLOTS-1:0] pending_reg, pending_next;
    logic [5:0]        prop_reg [POOL_SLOTS];
    logic [5:0]        prop_next [POOL_SLOTS];
    tap_req_t          req_reg, req_next;
    tap_rsp_t          rsp_reg;
    logic              rsp_valid_reg;

    logic [31:0] w_from_reg, w_from_next;
    logic [31:0] w_to_reg, w_to_next;
    logic [31:0] w_dur_reg, w_dur_next;
    logic [31:0] w_start_reg, w_start_next;
    logic [31:0] w_elapsed_reg, w_elapsed_next;
    logic        w_done_reg, w_done_next;
    logic        w_neg_reg, w_neg_next;

    logic          prop_wr_en, prop_rd_en;
    logic [AW-1:0] prop_wr_addr, prop_rd_addr;
    logic [31:0]   prop_wr_data, prop_rd_data;
    logic          slot_wr_en, slot_rd_en;
    logic [SW-1:0] slot_wr_addr, slot_rd_addr;
    tap_slot_t     slot_wr_data, slot_rd_data;

    logic        md_start, md_busy, md_done;
    logic [31:0] md_quot;
    logic [32:0] diff;
    logic [31:0] mag;

    logic          emit;
    tap_rsp_t      emit_data;
    logic          out_free;
    logic          req_prop_ok, reg_prop_ok;
    logic [POOL_SLOTS-1:0] match;
    logic          has_match, has_free, above;
    logic [SW-1:0] sel_match, sel_free, sel;
    logic [31:0]   start_sel, tick_val;
    tap_slot_t     slot_word;

    tap_ram #(.WIDTH(32), .DEPTH(PROPERTY_COUNT)) u_prop_ram (
        .clk     (clk),
        .wr_en   (prop_wr_en),
        .wr_addr (prop_wr_addr),
        .wr_data (prop_wr_data),
        .rd_en   (prop_rd_en),
        .rd_addr (prop_rd_addr),
        .rd_data (prop_rd_data)
    );

    tap_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    tap_muldiv u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (md_start),
        .mag      (mag),
        .elapsed  (w_elapsed_reg),
        .divisor  (w_dur_reg),
        .busy     (md_busy),
        .done     (md_done),
        .quotient (md_quot)
    );

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign req_prop_ok = 32'(req.prop_id) < 32'(PROPERTY_COUNT);
    assign reg_prop_ok = 32'(req_reg.prop_id) < 32'(PROPERTY_COUNT);

    assign diff = {w_to_reg[31], w_to_reg} - {w_from_reg[31], w_from_reg};
    assign mag  = diff[32] ? 32'(-diff) : diff[31:0];

    assign tick_val = w_done_reg ? w_to_reg :
                      (w_neg_reg ? (w_from_reg - md_quot) : (w_from_reg + md_quot));

    // Slot search for start and cancel: first matching slot, first free slot.
    always_comb
    begin
        has_match = 1'b0;
        has_free  = 1'b0;
        sel_match = '0;
        sel_free  = '0;
        above     = 1'b0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--)
        begin
            match[i] = active_reg[i] && (prop_reg[i] == req_reg.prop_id);
            if (match[i])
            begin
                has_match = 1'b1;
                sel_match = SW'(i);
            end
            if (!active_reg[i])
            begin
                has_free = 1'b1;
                sel_free = SW'(i);
            end
            if (active_reg[i] && (i > int'(idx_reg)))
            begin
                above = 1'b1;
            end
        end
        sel = has_match ? sel_match : sel_free;
    end

    assign start_sel = (state_reg == S_READ) ? 32'd0 : 32'd0;
    assign slot_word = slot_rd_data;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        active_next    = active_reg;
        pending_next   = pending_reg;
        prop_next      = prop_reg;
        req_next       = req_reg;
        w_from_next    = w_from_reg;
        w_to_next      = w_to_reg;
        w_dur_next     = w_dur_reg;
        w_start_next   = w_start_reg;
        w_elapsed_next = w_elapsed_reg;
        w_done_next    = w_done_reg;
        w_neg_next     = w_neg_reg;
        emit           = 1'b0;
        emit_data      = '0;
        prop_wr_en     = 1'b0;
        prop_wr_addr   = '0;
        prop_wr_data   = '0;
        prop_rd_en     = 1'b0;
        prop_rd_addr   = '0;
        slot_wr_en     = 1'b0;
        slot_wr_addr   = '0;
        slot_wr_data   = '0;
        slot_rd_en     = 1'b0;
        slot_rd_addr   = '0;
        md_start       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                prop_wr_en   = 1'b1;
                prop_wr_addr = clr_reg;
                if (clr_reg == AW'(PROPERTY_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    case (req.action)
                        ACT_START:
                        begin
                            prop_rd_en   = 1'b1;
                            prop_rd_addr = AW'(req.prop_id);
                            state_next   = S_START;
                        end
                        ACT_READ:
                        begin
                            prop_rd_en   = 1'b1;
                            prop_rd_addr = AW'(req.prop_id);
                            state_next   = S_READ;
                        end
                        ACT_CANCEL:
                        begin
                            state_next = S_CANCEL;
                        end
                        ACT_TICK:
                        begin
                            state_next = T_FIRST;
                        end
                        ACT_SET:
                        begin
                            prop_wr_en   = req_prop_ok;
                            prop_wr_addr = AW'(req.prop_id);
                            prop_wr_data = req.value;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_START:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (reg_prop_ok && (has_match || has_free))
                    begin
                        active_next[sel]  = 1'b1;
                        pending_next[sel] = 1'b1;
                        prop_next[sel]    = req_reg.prop_id;
                        slot_wr_en        = 1'b1;
                        slot_wr_addr      = sel;
                        slot_wr_data      = '{base_val: prop_rd_data, to_val: req_reg.value,
                                              duration: req_reg.span_ms,
                                              start_time: start_sel};
                        emit_data.slot    = 4'(sel);
                        emit_data.ok      = 1'b1;
                    end
                    emit_data.kind       = KIND_START;
                    emit_data.prop_out   = req_reg.prop_id;
                    emit_data.any_active = |active_next;
                    emit_data.last       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    emit                = 1'b1;
                    emit_data.kind      = KIND_READ;
                    emit_data.prop_out  = req_reg.prop_id;
                    emit_data.value_out = reg_prop_ok ? prop_rd_data : 32'd0;
                    emit_data.any_active = |active_reg;
                    emit_data.last      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            S_CANCEL:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (reg_prop_ok && has_match)
                    begin
                        active_next      = active_reg & ~match;
                        pending_next     = pending_reg & ~match;
                        emit_data.slot   = 4'(sel_match);
                        emit_data.ok     = 1'b1;
                        emit_data.done_res = 1'b1;
                    end
                    emit_data.kind       = KIND_CANCEL;
                    emit_data.prop_out   = req_reg.prop_id;
                    emit_data.any_active = |active_next;
                    emit_data.last       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            T_FIRST:
            begin
                if (|active_reg)
                begin
                    idx_next   = '0;
                    state_next = T_SCAN;
                end
                else if (out_free)
                begin
                    emit           = 1'b1;
                    emit_data.kind = KIND_IDLE_TICK;
                    emit_data.last = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            T_SCAN:
            begin
                if (active_reg[idx_reg])
                begin
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = idx_reg;
                    prop_rd_en   = 1'b1;
                    prop_rd_addr = AW'(prop_reg[idx_reg]);
                    state_next   = T_LOAD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            T_LOAD:
            begin
                // A pending slot takes its start point from this tick.
                w_from_next    = pending_reg[idx_reg] ? prop_rd_data : slot_word.base_val;
                w_start_next   = pending_reg[idx_reg] ? req_reg.now_ms : slot_word.start_time;
                w_to_next      = slot_word.to_val;
                w_dur_next     = slot_word.duration;
                w_elapsed_next = req_reg.now_ms - w_start_next;
                w_done_next    = w_elapsed_next >= slot_word.duration;
                state_next     = T_GO;
            end
            T_GO:
            begin
                w_neg_next = diff[32];
                if (w_done_reg)
                begin
                    state_next = T_EMIT;
                end
                else
                begin
                    md_start   = 1'b1;
                    state_next = T_WAIT;
                end
            end
            T_WAIT:
            begin
                if (md_done)
                begin
                    state_next = T_EMIT;
                end
            end
            T_EMIT:
            begin
                if (out_free)
                begin
                    prop_wr_en   = 1'b1;
                    prop_wr_addr = AW'(prop_reg[idx_reg]);
                    prop_wr_data = tick_val;
                    if (pending_reg[idx_reg])
                    begin
                        slot_wr_en   = 1'b1;
                        slot_wr_addr = idx_reg;
                        slot_wr_data = '{base_val: w_from_reg, to_val: w_to_reg,
                                         duration: w_dur_reg, start_time: w_start_reg};
                        pending_next[idx_reg] = 1'b0;
                    end
                    if (w_done_reg)
                    begin
                        active_next[idx_reg] = 1'b0;
                    end
                    emit                 = 1'b1;
                    emit_data.kind       = KIND_TICK;
                    emit_data.slot       = 4'(idx_reg);
                    emit_data.prop_out   = prop_reg[idx_reg];
                    emit_data.value_out  = tick_val;
                    emit_data.done_res   = w_done_reg;
                    emit_data.any_active = |active_next;
                    emit_data.last       = !above;
                    if (above)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = T_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            idx_reg       <= '0;
            active_reg    <= '0;
            pending_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                prop_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            idx_reg     <= idx_next;
            active_reg  <= active_next;
            pending_reg <= pending_next;
            prop_reg    <= prop_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        w_from_reg    <= w_from_next;
        w_to_reg      <= w_to_next;
        w_dur_reg     <= w_dur_next;
        w_start_reg   <= w_start_next;
        w_elapsed_reg <= w_elapsed_next;
        w_done_reg    <= w_done_next;
        w_neg_reg     <= w_neg_next;
        if (emit)
        begin
            rsp_reg <= emit_data;
        end
    end

    // Only tick updates may leave further results of the same request behind.
    `TAP_ASSERT_IMPL(a_single_last, rsp_valid && (rsp.kind != KIND_TICK), rsp.last)
    // An empty tick never reports an active pool.
    `TAP_ASSERT_IMPL(a_idle_tick, rsp_valid && (rsp.kind == KIND_IDLE_TICK), !rsp.any_active)
    // The divider is started only when it is free.
    `TAP_ASSERT_IMPL(a_md_free, md_start, !md_busy)
    // A new result is loaded only after the previous one left.
    `TAP_ASSERT_NEXT(a_no_overrun, rsp_valid && rsp_stall && !emit, $stable(rsp))

endmodule

`default_nettype wire

/* verif/tb_tween_animation_pool.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tween animation pool testbench
// Drives start, cancel, tick, set, read and undefined requests with random idle
// cycles and receiver stalls. Every response is checked against an in-bench
// prediction of the slot pool and the property store, or a fixed expected response.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tween_animation_pool
    import tap_pkg::*;
();

    localparam int NSLOT = POOL_SLOTS_DEF;
    localparam int NPROP = PROPERTY_COUNT_DEF;
    localparam logic [2:0] ACT_BAD_LO = 3'd5;
    localparam logic [2:0] ACT_BAD_MID = 3'd6;
    localparam logic [2:0] ACT_BAD_HI = 3'd7;

    typedef struct {
        tap_req_t r;
        bit       typed;
        tap_rsp_t rsp;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    tap_req_t req;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    tap_rsp_t rsp;

    // Predicted pool and store contents.
    bit          act_q[NSLOT];
    bit          pend_q[NSLOT];
    logic [5:0]  prop_q[NSLOT];
    logic [31:0] from_q[NSLOT];
    logic [31:0] to_q[NSLOT];
    logic [31:0] dur_q[NSLOT];
    logic [31:0] t0_q[NSLOT];
    logic [31:0] store_q[NPROP];

    tap_rsp_t    pending_rsp[$];
    stim_row_t   dir_rows[$];
    int          mismatches = 0;
    bit          calm;
    bit          hold_req;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    logic [31:0] now_t;

    tween_animation_pool u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("tween_animation_pool test failed");
        $finish;
    end

    function automatic bit pool_busy();
        foreach (act_q[i])
            if (act_q[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [31:0] lerp_q16(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] el, logic [31:0] d);
        longint      fa;
        longint      diff;
        logic [63:0] mag;
        logic [63:0] quo;
        longint      res;
        fa   = longint'($signed(a));
        diff = longint'($signed(b)) - fa;
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        quo  = (mag * {32'd0, el}) / {32'd0, d};
        res  = (diff < 0) ? fa - longint'(quo) : fa + longint'(quo);
        return res[31:0];
    endfunction

    function automatic tap_rsp_t mk_rsp(logic [2:0] k, logic [3:0] s, logic [5:0] p,
                                        logic [31:0] v, bit ok, bit dn, bit lst);
        tap_rsp_t o;
        o.kind       = k;
        o.slot       = s;
        o.prop_out   = p;
        o.value_out  = v;
        o.ok         = ok;
        o.done_res   = dn;
        o.any_active = pool_busy();
        o.last       = lst;
        return o;
    endfunction

    // Updates the predicted state for one request and queues its responses.
    task automatic predict_pool(input tap_req_t r);
        int          sel;
        int          lastidx;
        logic [31:0] el;
        logic [31:0] v;
        bit          dn;
        sel = -1;
        lastidx = -1;
        case (r.action)
            ACT_START:
            begin
                foreach (act_q[i])
                    if (sel < 0 && act_q[i] && prop_q[i] == r.prop_id) sel = i;
                foreach (act_q[i])
                    if (sel < 0 && !act_q[i]) sel = i;
                if (sel >= 0)
                begin
                    act_q[sel]  = 1'b1;
                    pend_q[sel] = 1'b1;
                    prop_q[sel] = r.prop_id;
                    from_q[sel] = store_q[r.prop_id];
                    to_q[sel]   = r.value;
                    dur_q[sel]  = r.span_ms;
                end
                pending_rsp.push_back(mk_rsp(KIND_START, (sel >= 0) ? 4'(sel) : 4'd0,
                                             r.prop_id, '0, sel >= 0, 1'b0, 1'b1));
            end
            ACT_CANCEL:
            begin
                foreach (act_q[i])
                    if (act_q[i] && prop_q[i] == r.prop_id)
                    begin
                        act_q[i]  = 1'b0;
                        pend_q[i] = 1'b0;
                        if (sel < 0) sel = i;
                    end
                pending_rsp.push_back(mk_rsp(KIND_CANCEL, (sel >= 0) ? 4'(sel) : 4'd0,
                                             r.prop_id, '0, sel >= 0, sel >= 0, 1'b1));
            end
            ACT_TICK:
            begin
                foreach (act_q[i])
                    if (act_q[i]) lastidx = i;
                if (lastidx < 0)
                    pending_rsp.push_back(mk_rsp(KIND_IDLE_TICK, '0, '0, '0, 0, 0, 1));
                else
                    foreach (act_q[i])
                    begin
                        if (!act_q[i]) continue;
                        if (pend_q[i])
                        begin
                            pend_q[i] = 1'b0;
                            t0_q[i]   = r.now_ms;
                            from_q[i] = store_q[prop_q[i]];
                        end
                        el = r.now_ms - t0_q[i];
                        dn = el >= dur_q[i];
                        if (dn)
                        begin
                            v = to_q[i];
                            act_q[i] = 1'b0;
                        end
                        else
                            v = lerp_q16(from_q[i], to_q[i], el, dur_q[i]);
                        store_q[prop_q[i]] = v;
                        pending_rsp.push_back(mk_rsp(KIND_TICK, 4'(i), prop_q[i], v, 0, dn,
                                                     i == lastidx));
                    end
            end
            ACT_SET:
                store_q[r.prop_id] = r.value;
            ACT_READ:
                pending_rsp.push_back(mk_rsp(KIND_READ, '0, r.prop_id, store_q[r.prop_id],
                                             0, 0, 1));
            default: ;
        endcase
    endtask

    // Offers one request until it is taken, then maybe idles the request side.
    task automatic send_req(input tap_req_t r, input bit typed, input tap_rsp_t rsp_fix);
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        predict_pool(r);
        if (typed)
        begin
            void'(pending_rsp.pop_back());
            pending_rsp.push_back(rsp_fix);
        end
        if (!calm && $urandom_range(99) < 32)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic tap_req_t mk_req(logic [2:0] a, logic [5:0] p, logic [31:0] v,
                                        logic [31:0] d, logic [31:0] n);
        tap_req_t r;
        r.action  = a;
        r.prop_id = p;
        r.value   = v;
        r.span_ms = d;
        r.now_ms  = n;
        return r;
    endfunction

    function automatic stim_row_t row(tap_req_t r, bit typed = 0, tap_rsp_t o = '0);
        stim_row_t s;
        s.r     = r;
        s.typed = typed;
        s.rsp   = o;
        return s;
    endfunction

    function automatic tap_rsp_t fixed(logic [2:0] k, logic [3:0] s, logic [5:0] p,
                                       logic [31:0] v, bit ok, bit dn, bit any);
        tap_rsp_t o;
        o = '{kind: k, slot: s, prop_out: p, value_out: v, ok: ok, done_res: dn,
              any_active: any, last: 1'b1};
        return o;
    endfunction

    function automatic tap_req_t rand_req();
        int          pick;
        logic [5:0]  p;
        logic [31:0] d;
        pick = $urandom_range(99);
        p = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(15));
        d = ($urandom_range(7) == 0) ? $urandom : $urandom_range(200);
        if ($urandom_range(15) == 0)
            now_t = $urandom;
        else
            now_t = now_t + $urandom_range(50);
        if (pick < 30) return mk_req(ACT_START, p, $urandom, d, $urandom);
        if (pick < 40) return mk_req(ACT_CANCEL, p, $urandom, $urandom, $urandom);
        if (pick < 65) return mk_req(ACT_TICK, 6'($urandom), $urandom, $urandom, now_t);
        if (pick < 80) return mk_req(ACT_SET, p, $urandom, $urandom, $urandom);
        if (pick < 95) return mk_req(ACT_READ, p, $urandom, $urandom, $urandom);
        return mk_req(3'($urandom_range(5, 7)), p, $urandom, $urandom, $urandom);
    endfunction

    // Response side: random stalls, plus one long hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= 400;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= !calm && ($urandom_range(99) < 32);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", rsp);
            end
            else
            begin
                tap_rsp_t exp_r;
                exp_r = pending_rsp.pop_front();
                if (rsp.kind !== exp_r.kind || rsp.slot !== exp_r.slot
                    || rsp.prop_out !== exp_r.prop_out || rsp.value_out !== exp_r.value_out
                    || rsp.ok !== exp_r.ok || rsp.done_res !== exp_r.done_res
                    || rsp.any_active !== exp_r.any_active || rsp.last !== exp_r.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_r, rsp);
                end
            end
        end
    end

    initial
    begin
        int wait_cnt;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        now_t      = 32'd2000;
        foreach (act_q[i])
        begin
            act_q[i]  = 1'b0;
            pend_q[i] = 1'b0;
            prop_q[i] = '0;
        end
        foreach (store_q[i]) store_q[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows.push_back(row(mk_req(ACT_READ, 6'd0, '0, '0, '0), 1,
                               fixed(KIND_READ, 0, 6'd0, '0, 0, 0, 0)));
        dir_rows.push_back(row(mk_req(ACT_TICK, 6'd0, '0, '0, 32'd7), 1,
                               fixed(KIND_IDLE_TICK, 0, 6'd0, '0, 0, 0, 0)));
        dir_rows.push_back(row(mk_req(ACT_CANCEL, 6'd5, '0, '0, '0), 1,
                               fixed(KIND_CANCEL, 0, 6'd5, '0, 0, 0, 0)));
        dir_rows.push_back(row(mk_req(ACT_SET, 6'd63, 32'h7fff_ffff, '0, '0)));
        dir_rows.push_back(row(mk_req(ACT_READ, 6'd63, '0, '0, '0), 1,
                               fixed(KIND_READ, 0, 6'd63, 32'h7fff_ffff, 0, 0, 0)));
        dir_rows.push_back(row(mk_req(ACT_SET, 6'd1, 32'h8000_0000, '0, '0)));
        dir_rows.push_back(row(mk_req(ACT_START, 6'd1, 32'h7fff_ffff, 32'hffff_ffff, '0), 1,
                               fixed(KIND_START, 0, 6'd1, '0, 1, 0, 1)));
        dir_rows.push_back(row(mk_req(ACT_START, 6'd2, 32'h0001_0000, 32'd0, '0)));
        // Time wraps between these two ticks.
        dir_rows.push_back(row(mk_req(ACT_TICK, '0, '0, '0, 32'hffff_ffff)));
        dir_rows.push_back(row(mk_req(ACT_TICK, '0, '0, '0, 32'd5)));
        dir_rows.push_back(row(mk_req(ACT_START, 6'd1, 32'h1234_5678, 32'd10, '0)));
        dir_rows.push_back(row(mk_req(ACT_CANCEL, 6'd1, '0, '0, '0), 1,
                               fixed(KIND_CANCEL, 0, 6'd1, '0, 1, 1, 0)));
        dir_rows.push_back(row(mk_req(ACT_BAD_LO, 6'd3, '1, '1, '1)));
        dir_rows.push_back(row(mk_req(ACT_BAD_MID, 6'd3, '1, '1, '1)));
        dir_rows.push_back(row(mk_req(ACT_BAD_HI, 6'd3, '1, '1, '1)));
        // Fill every slot, then one more start finds the pool full.
        for (int i = 0; i < NSLOT; i++)
            dir_rows.push_back(row(mk_req(ACT_START, 6'(20 + i), $urandom, 32'd1000, '0)));
        dir_rows.push_back(row(mk_req(ACT_START, 6'd50, '0, 32'd5, '0), 1,
                               fixed(KIND_START, 0, 6'd50, '0, 0, 0, 1)));
        dir_rows.push_back(row(mk_req(ACT_TICK, '0, '0, '0, 32'd100)));
        dir_rows.push_back(row(mk_req(ACT_TICK, '0, '0, '0, 32'd500)));
        dir_rows.push_back(row(mk_req(ACT_TICK, '0, '0, '0, 32'd2000)));

        foreach (dir_rows[i])
            send_req(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].rsp);

        for (int n = 0; n < 75; n++)
        begin
            calm = (n >= 20 && n < 45);
            if (n == 60) hold_req = 1'b1;
            send_req(rand_req(), 0, '0);
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        wait_cnt = 0;
        while (pending_rsp.size() != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (800) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("tween_animation_pool test passed");
        else
            $display("tween_animation_pool test failed");
        $finish;
    end

endmodule

`default_nettype wire
